/* rtl/cau_pkg.sv */
// Shared constants and operation codes for the complex arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

	// Default word layout: signed Q8.24.
	localparam int WORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF = 24;
	localparam int MAX_EXP_DEF   = 15;

	// Field widths fixed by the command format.
	localparam int OP_W  = 2;
	localparam int EXP_W = 4;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_MUL = 2'd0;
	localparam logic [OP_W-1:0] OP_DIV = 2'd1;
	localparam logic [OP_W-1:0] OP_SUB = 2'd2;
	localparam logic [OP_W-1:0] OP_POW = 2'd3;

endpackage

`default_nettype wire

/* rtl/cau_in_if.sv */
// Command channel of the complex arithmetic unit: operation, operands and exponent.
`timescale 1ns / 1ps
`default_nettype none

interface cau_in_if #(
	parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF
);
	import cau_pkg::*;

	logic                        valid;
	logic                        ready;
	logic        [OP_W-1:0]      action;
	logic signed [WORD_BITS-1:0] a_re;
	logic signed [WORD_BITS-1:0] a_im;
	logic signed [WORD_BITS-1:0] b_re;
	logic signed [WORD_BITS-1:0] b_im;
	logic        [EXP_W-1:0]     exponent;

	modport source (
		output valid, action, a_re, a_im, b_re, b_im, exponent,
		input  ready
	);

	modport sink (
		input  valid, action, a_re, a_im, b_re, b_im, exponent,
		output ready
	);

endinterface

`default_nettype wire

/* rtl/cau_out_if.sv */
// Result channel of the complex arithmetic unit: complex result and status flags.
`timescale 1ns / 1ps
`default_nettype none

interface cau_out_if #(
	parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF
);
	logic                        valid;
	logic                        ready;
	logic signed [WORD_BITS-1:0] res_re;
	logic signed [WORD_BITS-1:0] res_im;
	logic                        div_zero;
	logic                        overflow;

	modport source (
		output valid, res_re, res_im, div_zero, overflow,
		input  ready
	);

	modport sink (
		input  valid, res_re, res_im, div_zero, overflow,
		output ready
	);

endinterface

`default_nettype wire

/* rtl/cau_mul.sv */
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none

module cau_mul #(
	parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF
) (
	input  wire                          clk,
	input  wire logic signed [WORD_BITS-1:0]   x,
	input  wire logic signed [WORD_BITS-1:0]   y,
	output logic signed [2*WORD_BITS-1:0]      prod
);
	import cau_pkg::*;

	logic signed [2*WORD_BITS-1:0] prod_s1;

	// The full-width product is exact, so no rounding happens here.
	always_ff @(posedge clk) begin
		prod_s1 <= x * y;
	end

	assign prod = prod_s1;

endmodule

`default_nettype wire

/* rtl/cau_div.sv */
// Restoring divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module cau_div #(
	parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
	input  wire                                          clk,
	input  wire                                          arst_n,
	input  wire                                          start,
	input  wire logic [2*WORD_BITS:0]                    num,
	input  wire logic [2*WORD_BITS-1:0]                  den,
	output logic                                         done,
	output logic [2*WORD_BITS+FRAC_BITS:0]               quot
);
	import cau_pkg::*;

	localparam int NUM_W = 2 * WORD_BITS + 1;
	localparam int DVD_W = NUM_W + FRAC_BITS;
	localparam int REM_W = 2 * WORD_BITS + 1;
	localparam int CNT_W = $clog2(DVD_W);

	logic [REM_W-1:0] rem_q;
	logic [DVD_W-1:0] dvd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [REM_W-1:0] trial;
	logic [REM_W-1:0] den_ext;
	logic [REM_W-1:0] diff;
	logic             ge;

	// The dividend shifts out at the top while quotient bits shift in at the bottom.
	assign trial   = {rem_q[REM_W-2:0], dvd_q[DVD_W-1]};
	assign den_ext = {1'b0, den};
	assign ge      = (trial >= den_ext);
	assign diff    = trial - den_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= {num, {FRAC_BITS{1'b0}}};
		end else if (busy_q) begin
			rem_q <= ge ? diff : trial;
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = dvd_q;

endmodule

`default_nettype wire

/* rtl/cau_sat.sv */
// Clamps a wide signed value to the word range and flags when it had to.
`timescale 1ns / 1ps
`default_nettype none

module cau_sat #(
	parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
	parameter int IN_W      = 2 * cau_pkg::WORD_BITS_DEF
) (
	input  wire logic signed [IN_W-1:0]      din,
	output logic signed [WORD_BITS-1:0]      dout,
	output logic                             ovf
);
	import cau_pkg::*;

	localparam logic signed [IN_W-1:0] MAXV =
		{{(IN_W - WORD_BITS + 1){1'b0}}, {(WORD_BITS - 1){1'b1}}};
	localparam logic signed [IN_W-1:0] MINV =
		{{(IN_W - WORD_BITS + 1){1'b1}}, {(WORD_BITS - 1){1'b0}}};

	always_comb begin
		if (din > MAXV) begin
			dout = MAXV[WORD_BITS-1:0];
			ovf  = 1'b1;
		end else if (din < MINV) begin
			dout = MINV[WORD_BITS-1:0];
			ovf  = 1'b1;
		end else begin
			dout = din[WORD_BITS-1:0];
			ovf  = 1'b0;
		end
	end

endmodule

`default_nettype wire

/* rtl/complex_arithmetic_unit.sv */
// Top level of the complex arithmetic unit: sequencer, operand registers and result register.
//
// Usage: a command transaction on cmd carries the operation (multiply, divide, subtract,
// power), two complex operands in signed fixed point and an exponent. Exactly one result
// transaction on res follows for each command, carrying the saturated complex result,
// a divide-by-zero flag and a sticky overflow flag.
// One command is worked at a time; cmd.ready is high only while the sequencer is idle.
// All products go through one shared multiplier (one product per cycle, registered),
// and division runs on a restoring divider that produces one quotient bit per cycle.
// The default operand layout is Q8.24. Power with an exponent below two returns A
// unchanged; a divide runs two serial quotient passes, one for the real and one for
// the imaginary part, and a zero divisor skips both passes.
// The finished result moves into an output register, so a new command is taken while the
// previous result still waits for res.ready. When the receiver stalls longer, the
// sequencer holds its finished result until the output register frees up.
// An asynchronous low reset on arst_n returns the sequencer to idle and empties the
// output register; operand and result data are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module complex_arithmetic_unit #(
	parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF,
	parameter int MAX_EXP   = cau_pkg::MAX_EXP_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	cau_in_if.sink     cmd,
	cau_out_if.source  res
);
	import cau_pkg::*;

	localparam int W     = WORD_BITS;
	localparam int ACC_W = 2 * W + 1;
	localparam int DVD_W = ACC_W + FRAC_BITS;
	localparam int SAT_W = DVD_W + 1;

	// Sequencer states.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_SAT   = 3'd2;
	localparam logic [2:0] ST_DVCHK = 3'd3;
	localparam logic [2:0] ST_DVRE  = 3'd4;
	localparam logic [2:0] ST_DVIM  = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	// Products per operation: a complex multiply needs four, a divide two more for |B|^2.
	localparam logic [2:0] NPROD_MUL = 3'd4;
	localparam logic [2:0] NPROD_DIV = 3'd6;

	logic [2:0]       state_q;
	logic [2:0]       step_q;
	logic [EXP_W-1:0] cnt_q;
	logic [OP_W-1:0]  op_q;

	// For power, x holds the running result and b holds the base.
	logic signed [W-1:0] xr_q, xi_q, br_q, bi_q;
	logic signed [ACC_W-1:0] acc_re_q, acc_im_q, den_q;
	logic ovf_q, dz_q, neg_q;

	logic                out_valid_q;
	logic signed [W-1:0] out_re_q, out_im_q;
	logic                out_dz_q, out_ovf_q;

	logic             accept;
	logic             out_free;
	logic             is_div;
	logic [2:0]       nprod;
	logic             mul_last;
	logic             pow_more;
	logic             den_zero;
	logic [EXP_W-1:0] e_clamp;
	logic [2:0]       acc_k;

	logic signed [W-1:0]     mul_x, mul_y;
	logic signed [2*W-1:0]   prod;
	logic signed [ACC_W-1:0] pe;

	logic                    div_start, div_done;
	logic signed [ACC_W-1:0] num_sel;
	logic [ACC_W-1:0]        num_mag;
	logic [DVD_W-1:0]        div_quot;
	logic signed [SAT_W-1:0] q_ext, q_signed;

	logic signed [ACC_W-1:0] sh_re, sh_im;
	logic signed [W:0]       df_re, df_im;
	logic signed [SAT_W-1:0] sat0_in, sat1_in;
	logic signed [W-1:0]     sat0_out, sat1_out;
	logic                    sat0_ovf, sat1_ovf;

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign out_free  = !out_valid_q || res.ready;
	assign is_div    = (op_q == OP_DIV);
	assign nprod     = is_div ? NPROD_DIV : NPROD_MUL;
	assign mul_last  = (step_q == nprod);
	assign pow_more  = (op_q == OP_POW) && (cnt_q != EXP_W'(1));
	assign den_zero  = (den_q == '0);
	assign acc_k     = step_q - 3'd1;

	assign e_clamp = (32'(cmd.exponent) > MAX_EXP) ? EXP_W'(MAX_EXP) : cmd.exponent;

	// Operand selection for the product issued in this step. The divide numerator
	// reuses the multiply operand order; only the signs differ.
	always_comb begin
		case (step_q)
			3'd0: begin
				mul_x = xr_q;
				mul_y = br_q;
			end
			3'd1: begin
				mul_x = xi_q;
				mul_y = bi_q;
			end
			3'd2: begin
				mul_x = xr_q;
				mul_y = bi_q;
			end
			3'd3: begin
				mul_x = xi_q;
				mul_y = br_q;
			end
			3'd4: begin
				mul_x = br_q;
				mul_y = br_q;
			end
			3'd5: begin
				mul_x = bi_q;
				mul_y = bi_q;
			end
			default: begin
				mul_x = xr_q;
				mul_y = br_q;
			end
		endcase
	end

	cau_mul #(
		.WORD_BITS(W)
	) u_mul (
		.clk (clk),
		.x   (mul_x),
		.y   (mul_y),
		.prod(prod)
	);

	assign pe = ACC_W'(prod);

	// The divider works on magnitudes; the sign of the numerator is reapplied afterward.
	assign num_sel   = (state_q == ST_DVCHK) ? acc_re_q : acc_im_q;
	assign num_mag   = num_sel[ACC_W-1] ? ACC_W'(-num_sel) : ACC_W'(num_sel);
	assign div_start = ((state_q == ST_DVCHK) && !den_zero) ||
	                   ((state_q == ST_DVRE) && div_done);

	cau_div #(
		.WORD_BITS(W),
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (num_mag),
		.den   (den_q[2*W-1:0]),
		.done  (div_done),
		.quot  (div_quot)
	);

	assign q_ext    = $signed({1'b0, div_quot});
	assign q_signed = neg_q ? -q_ext : q_ext;

	// Product sums are floored by the arithmetic shift before saturation.
	assign sh_re = acc_re_q >>> FRAC_BITS;
	assign sh_im = acc_im_q >>> FRAC_BITS;
	assign df_re = $signed({xr_q[W-1], xr_q}) - $signed({br_q[W-1], br_q});
	assign df_im = $signed({xi_q[W-1], xi_q}) - $signed({bi_q[W-1], bi_q});

	always_comb begin
		if (state_q == ST_DVRE || state_q == ST_DVIM) begin
			sat0_in = q_signed;
		end else if (op_q == OP_SUB) begin
			sat0_in = SAT_W'(df_re);
		end else begin
			sat0_in = SAT_W'(sh_re);
		end
		if (op_q == OP_SUB) begin
			sat1_in = SAT_W'(df_im);
		end else begin
			sat1_in = SAT_W'(sh_im);
		end
	end

	cau_sat #(
		.WORD_BITS(W),
		.IN_W     (SAT_W)
	) u_sat0 (
		.din (sat0_in),
		.dout(sat0_out),
		.ovf (sat0_ovf)
	);

	cau_sat #(
		.WORD_BITS(W),
		.IN_W     (SAT_W)
	) u_sat1 (
		.din (sat1_in),
		.dout(sat1_out),
		.ovf (sat1_ovf)
	);

	// Sequencer and output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A finished result refills the output register in the same cycle that the
			// previous one leaves.
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						step_q <= '0;
						cnt_q  <= e_clamp - EXP_W'(1);
						case (cmd.action)
							OP_SUB:  state_q <= ST_SAT;
							OP_POW:  state_q <= (e_clamp < EXP_W'(2)) ? ST_DONE : ST_MUL;
							default: state_q <= ST_MUL;
						endcase
					end
				end
				ST_MUL: begin
					if (mul_last) begin
						step_q  <= '0;
						state_q <= is_div ? ST_DVCHK : ST_SAT;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				ST_SAT: begin
					if (pow_more) begin
						cnt_q   <= cnt_q - EXP_W'(1);
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DVCHK: begin
					state_q <= den_zero ? ST_DONE : ST_DVRE;
				end
				ST_DVRE: begin
					if (div_done) begin
						state_q <= ST_DVIM;
					end
				end
				ST_DVIM: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Operand, accumulator and result data.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q  <= cmd.action;
					xr_q  <= cmd.a_re;
					xi_q  <= cmd.a_im;
					ovf_q <= 1'b0;
					dz_q  <= 1'b0;
					if (cmd.action == OP_POW) begin
						br_q <= cmd.a_re;
						bi_q <= cmd.a_im;
					end else begin
						br_q <= cmd.b_re;
						bi_q <= cmd.b_im;
					end
				end
			end
			ST_MUL: begin
				// Fold in the product issued in the previous step.
				if (step_q != 3'd0) begin
					case (acc_k)
						3'd0: acc_re_q <= pe;
						3'd1: acc_re_q <= is_div ? acc_re_q + pe : acc_re_q - pe;
						3'd2: acc_im_q <= is_div ? -pe : pe;
						3'd3: acc_im_q <= acc_im_q + pe;
						3'd4: den_q    <= pe;
						3'd5: den_q    <= den_q + pe;
						default: den_q <= den_q;
					endcase
				end
			end
			ST_SAT: begin
				xr_q  <= sat0_out;
				xi_q  <= sat1_out;
				ovf_q <= ovf_q | sat0_ovf | sat1_ovf;
			end
			ST_DVCHK: begin
				if (den_zero) begin
					dz_q <= 1'b1;
					xr_q <= '0;
					xi_q <= '0;
				end else begin
					neg_q <= acc_re_q[ACC_W-1];
				end
			end
			ST_DVRE: begin
				if (div_done) begin
					xr_q  <= sat0_out;
					ovf_q <= ovf_q | sat0_ovf;
					neg_q <= acc_im_q[ACC_W-1];
				end
			end
			ST_DVIM: begin
				if (div_done) begin
					xi_q  <= sat0_out;
					ovf_q <= ovf_q | sat0_ovf;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_re_q  <= xr_q;
					out_im_q  <= xi_q;
					out_dz_q  <= dz_q;
					out_ovf_q <= ovf_q;
				end
			end
			default: begin
				op_q <= op_q;
			end
		endcase
	end

	assign res.valid    = out_valid_q;
	assign res.res_re   = out_re_q;
	assign res.res_im   = out_im_q;
	assign res.div_zero = out_dz_q;
	assign res.overflow = out_ovf_q;

	// A command transaction always starts a computation, so ready must drop next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !cmd.ready)
		else $error("cmd.ready stayed high after a command was taken");

	// A zero divisor gives a zero result and never reports overflow.
	a_div_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.div_zero |->
			res.res_re == '0 && res.res_im == '0 && !res.overflow)
		else $error("zero-divisor result is not zero or reports overflow");

	// The divider finishes only while the sequencer waits for a quotient.
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DVRE || state_q == ST_DVIM))
		else $error("divider finished outside a divide step");

endmodule

`default_nettype wire
